>>> rtl/poly_trajectory_pos_vel_acc_assert.svh
// Assertion macros for the trajectory evaluator checker.
// Each macro expands to one labelled concurrent assertion on i_clk.
`ifndef POLY_TRAJECTORY_POS_VEL_ACC_ASSERT_SVH
`define POLY_TRAJECTORY_POS_VEL_ACC_ASSERT_SVH

// Condition holds in the same cycle as the antecedent, outside reset.
`define PTPVA_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trajectory evaluator check failed");

// Condition holds in the cycle after the antecedent, outside reset.
`define PTPVA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trajectory evaluator check failed");

// Condition holds in the cycle after reset is seen active.
`define PTPVA_CHECK_RESET(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("trajectory evaluator reset check failed");

`endif

>>> rtl/ptpva_pkg.sv
`default_nettype none

package ptpva_pkg;

    localparam int DATA_W          = 32;
    localparam int NUM_COEF        = 6;
    localparam int MAX_DEGREE      = NUM_COEF - 1;
    localparam int POLY_DEGREE_DEF = 5;
    localparam int ADDR_W          = 5;
    localparam int REG_IDX_W       = 3;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_COEF_C0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_C1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_C2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_C3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_C4   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_C5   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SEG_START = 3'd6;

    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat;

    // One request as it moves along the chain of Horner cells.
    typedef struct packed {
        logic signed [31:0] dt;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               sat;
    } t_lane;

    function automatic t_sat sat32(input logic signed [48:0] v);
        t_sat r;
        if (v > SAT_HI) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    // Scales a coefficient by a small constant for the derivative polynomials.
    function automatic t_sat scale_coef(input logic signed [31:0] c, input logic [4:0] m);
        logic [48:0] p;
        p = {{17{c[31]}}, c} * {44'd0, m};
        return sat32(p);
    endfunction

    // One Horner step: round(acc * dt / 2^16) + coef, ties towards plus infinity.
    function automatic t_sat horner_step(input logic signed [31:0] acc,
                                         input logic signed [31:0] dt,
                                         input logic signed [31:0] coef);
        logic signed [63:0] prod;
        logic signed [63:0] biased;
        logic        [48:0] sum;
        prod   = acc * dt;
        biased = prod + 64'sd32768;
        sum    = {biased[63], biased[63:16]} + {{17{coef[31]}}, coef};
        return sat32(sum);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ptpva_cell.sv
`default_nettype none

module ptpva_cell #(
    parameter bit LOAD_VEL = 1'b0,
    parameter bit LOAD_ACC = 1'b0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ptpva_pkg::t_lane  i_lane,
    input  wire logic signed [31:0] i_coef_pos,
    input  wire logic signed [31:0] i_coef_vel,
    input  wire logic signed [31:0] i_coef_acc,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ptpva_pkg::t_lane       o_lane
);
    import ptpva_pkg::*;

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    t_sat  w_pos;
    t_sat  w_vel;
    t_sat  w_acc;
    logic  w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // A lane that starts here loads its leading coefficient instead of stepping.
    always_comb begin
        w_pos = horner_step(i_lane.pos, i_lane.dt, i_coef_pos);
        if (LOAD_VEL) begin
            w_vel = '{clip: 1'b0, val: i_coef_vel};
        end else begin
            w_vel = horner_step(i_lane.vel, i_lane.dt, i_coef_vel);
        end
        if (LOAD_ACC) begin
            w_acc = '{clip: 1'b0, val: i_coef_acc};
        end else begin
            w_acc = horner_step(i_lane.acc, i_lane.dt, i_coef_acc);
        end
        n_lane.dt  = i_lane.dt;
        n_lane.pos = w_pos.val;
        n_lane.vel = w_vel.val;
        n_lane.acc = w_acc.val;
        n_lane.sat = i_lane.sat | w_pos.clip | w_vel.clip | w_acc.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

>>> rtl/poly_trajectory_pos_vel_acc.sv
`default_nettype none
// Trajectory segment evaluator: position, velocity and acceleration of one
// polynomial segment, all signed Q16.16.
// Configuration is written over the APB-style port: coefficients c0..c5 at
// byte addresses 0x00..0x14 and the segment start time at 0x18, with paddr[1:0]
// ignored. Writes to 0x1C are ignored and read back as zero. Registers are to be written
// only while no request is in flight; the block itself does not enforce this.
// Requests enter on i_valid/o_ready carrying i_sample_time. Each produces
// one result on o_valid/i_ready: o_position, o_velocity, o_acceleration and
// o_saturated, which is set when any intermediate was clipped to 32 bits.
// Throughput is one request per clock cycle while i_ready is held high. With D
// the effective degree (POLY_DEGREE capped at five), one entry stage forms
// the time offset and loads c[D], then D Horner cells each apply one
// coefficient to every polynomial that has started, with their own multipliers.
// Every stage has its own valid bit, so a stalled receiver stops only the
// stages that hold requests; empty stages keep accepting until the chain is
// full, and o_ready then follows i_ready.
// Synchronous reset empties the chain and clears the coefficient and segment start registers to zero.

module poly_trajectory_pos_vel_acc #(
    parameter int POLY_DEGREE = ptpva_pkg::POLY_DEGREE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ptpva_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [31:0]           i_sample_time,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [31:0]                o_position,
    output logic signed [31:0]                o_velocity,
    output logic signed [31:0]                o_acceleration,
    output logic                              o_saturated
);
    import ptpva_pkg::*;

    // Only c0..c5 exist, so degrees above five are evaluated as five.
    localparam int EFF_DEG = (POLY_DEGREE > MAX_DEGREE) ? MAX_DEGREE : POLY_DEGREE;

    logic signed [31:0]   r_coef [NUM_COEF];
    logic signed [31:0]   r_seg_start;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
            r_seg_start <= '0;
        end else if (w_wr) begin
            unique case (w_idx) inside
                REG_COEF_C0, REG_COEF_C1, REG_COEF_C2,
                REG_COEF_C3, REG_COEF_C4, REG_COEF_C5: begin
                    r_coef[w_idx] <= pwdata;
                end
                REG_SEG_START: begin
                    r_seg_start <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx) inside
            REG_COEF_C0, REG_COEF_C1, REG_COEF_C2,
            REG_COEF_C3, REG_COEF_C4, REG_COEF_C5: begin
                prdata = r_coef[w_idx];
            end
            REG_SEG_START: begin
                prdata = r_seg_start;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Derivative coefficients: vc[i] = (i+1) * c[i+1] for velocity and
    // ac[i] = (i+2) * (i+1) * c[i+2] for acceleration. They depend on the
    // configuration alone, so their clip flags are folded in at entry.
    logic signed [31:0] w_vc      [MAX_DEGREE];
    logic signed [31:0] w_ac      [MAX_DEGREE-1];
    logic [MAX_DEGREE-1:0] w_vc_clip;
    logic [MAX_DEGREE-2:0] w_ac_clip;
    logic                  w_cfg_clip;

    for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_vel_coef
        t_sat w_s;
        assign w_s          = scale_coef(r_coef[i+1], 5'(i + 1));
        assign w_vc[i]      = w_s.val;
        assign w_vc_clip[i] = (i + 1 <= EFF_DEG) ? w_s.clip : 1'b0;
    end

    for (genvar i = 0; i < MAX_DEGREE - 1; i++) begin : g_acc_coef
        t_sat w_s;
        assign w_s          = scale_coef(r_coef[i+2], 5'((i + 2) * (i + 1)));
        assign w_ac[i]      = w_s.val;
        assign w_ac_clip[i] = (i + 2 <= EFF_DEG) ? w_s.clip : 1'b0;
    end

    assign w_cfg_clip = (|w_vc_clip) | (|w_ac_clip);

    // Entry stage: the saturated time offset and the leading position term.
    logic        r_ent_valid;
    t_lane       r_ent_lane;
    t_lane       n_ent_lane;
    t_sat        w_dt;
    logic [48:0] w_dt_wide;

    logic  w_valid [EFF_DEG+1];
    logic  w_ready [EFF_DEG+1];
    t_lane w_lane  [EFF_DEG+1];

    assign w_dt_wide = {{17{i_sample_time[31]}}, i_sample_time}
                     - {{17{r_seg_start[31]}}, r_seg_start};

    always_comb begin
        w_dt           = sat32(w_dt_wide);
        n_ent_lane.dt  = w_dt.val;
        n_ent_lane.pos = r_coef[EFF_DEG];
        n_ent_lane.vel = '0;
        n_ent_lane.acc = '0;
        n_ent_lane.sat = w_dt.clip | w_cfg_clip;
    end

    assign o_ready = !r_ent_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
        end else if (o_ready) begin
            r_ent_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ent_lane <= n_ent_lane;
        end
    end

    assign w_valid[0] = r_ent_valid;
    assign w_lane[0]  = r_ent_lane;

    // Cell j applies coefficient D-j to position. Velocity starts one cell
    // later and acceleration two cells later, so all three end in cell D.
    for (genvar j = 1; j <= EFF_DEG; j++) begin : g_cell
        localparam int VEL_IDX = (j == 1) ? EFF_DEG - 1 : EFF_DEG - j;
        localparam int ACC_IDX = (j <= 2) ? EFF_DEG - 2 : EFF_DEG - j;

        ptpva_cell #(
            .LOAD_VEL (j == 1),
            .LOAD_ACC (j <= 2)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_valid[j-1]),
            .o_ready    (w_ready[j-1]),
            .i_lane     (w_lane[j-1]),
            .i_coef_pos (r_coef[EFF_DEG-j]),
            .i_coef_vel (w_vc[VEL_IDX]),
            .i_coef_acc (w_ac[ACC_IDX]),
            .o_valid    (w_valid[j]),
            .i_ready    (w_ready[j]),
            .o_lane     (w_lane[j])
        );
    end

    // The last cell's registers are the result register.
    assign w_ready[EFF_DEG] = i_ready;
    assign o_valid          = w_valid[EFF_DEG];
    assign o_position       = w_lane[EFF_DEG].pos;
    assign o_velocity       = w_lane[EFF_DEG].vel;
    assign o_acceleration   = w_lane[EFF_DEG].acc;
    assign o_saturated      = w_lane[EFF_DEG].sat;

endmodule

`default_nettype wire

>>> rtl/ptpva_checker.sv
`default_nettype none
`include "poly_trajectory_pos_vel_acc_assert.svh"

module ptpva_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_position,
    input wire logic [31:0] o_velocity,
    input wire logic [31:0] o_acceleration,
    input wire logic        o_saturated
);

    // Reset empties the chain, so no result is offered straight after it.
    `PTPVA_CHECK_RESET(a_reset_empty, !o_valid)

    // A stalled result stays offered and unchanged.
    `PTPVA_CHECK_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_position) && $stable(o_velocity) && $stable(o_acceleration) && $stable(o_saturated))

    // With no result waiting every stage can move, so requests are taken.
    `PTPVA_CHECK(a_empty_ready, !o_valid, o_ready)

    // Requests are refused only when a result is held by the receiver.
    `PTPVA_CHECK(a_stall_cause, !o_ready, o_valid && !i_ready)

endmodule

bind poly_trajectory_pos_vel_acc ptpva_checker u_ptpva_checker (.*);

`default_nettype wire

>>> test/poly_trajectory_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and the request and result channels of
// the trajectory evaluator, keeps its own copy of the segment registers and
// predicts position, velocity and acceleration of every accepted request.
module poly_trajectory_checker #(
    parameter int POLY_DEGREE = ptpva_pkg::POLY_DEGREE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [ptpva_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic signed [31:0]           i_sample_time,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic signed [31:0]           o_position,
    input  logic signed [31:0]           o_velocity,
    input  logic signed [31:0]           o_acceleration,
    input  logic                         o_saturated,
    output int                           o_fail_count,
    output int                           o_outstanding
);
    import ptpva_pkg::*;

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               sat;
    } t_motion;

    longint  coef_reg [NUM_COEF];
    longint  start_reg;
    t_motion expected_motion [$];
    int      fail_count = 0;
    int      outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > S32_HI) begin
            clipped = 1'b1;
            return S32_HI;
        end
        if (v < S32_LO) begin
            clipped = 1'b1;
            return S32_LO;
        end
        return v;
    endfunction

    // Horner's rule, one rounded Q16.16 multiply per coefficient.
    function automatic longint horner_eval(input longint a [NUM_COEF], input int top,
                                           input longint x, inout bit clipped);
        longint acc;
        if (top < 0)
            return 0;
        acc = clip32(a[top], clipped);
        for (int k = top - 1; k >= 0; k--)
            acc = clip32(((acc * x + 64'sd32768) >>> 16) + clip32(a[k], clipped), clipped);
        return acc;
    endfunction

    function automatic t_motion eval_segment(input logic signed [31:0] t);
        t_motion m;
        bit      clipped;
        int      deg;
        longint  dt;
        longint  vc [NUM_COEF];
        longint  ac [NUM_COEF];
        clipped = 1'b0;
        deg = (POLY_DEGREE > MAX_DEGREE) ? MAX_DEGREE : POLY_DEGREE;
        if (deg < 0)
            deg = 0;
        dt = clip32(longint'(t) - start_reg, clipped);
        for (int k = 0; k < NUM_COEF; k++) begin
            vc[k] = 0;
            ac[k] = 0;
        end
        for (int k = 1; k <= deg; k++)
            vc[k - 1] = clip32(longint'(k) * coef_reg[k], clipped);
        for (int k = 2; k <= deg; k++)
            ac[k - 2] = clip32(longint'(k * (k - 1)) * coef_reg[k], clipped);
        m.pos = 32'(horner_eval(coef_reg, deg, dt, clipped));
        m.vel = 32'(horner_eval(vc, deg - 1, dt, clipped));
        m.acc = 32'(horner_eval(ac, deg - 2, dt, clipped));
        m.sat = clipped;
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_motion                want;
        logic [REG_IDX_W-1:0]   idx;
        int                     pushed;
        int                     popped;
        pushed = 0;
        popped = 0;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++)
                coef_reg[k] = 0;
            start_reg = 0;
            expected_motion.delete();
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr[ADDR_W-1:2];
                if (idx <= REG_COEF_C5)
                    coef_reg[idx] = longint'(signed'(pwdata));
                else if (idx == REG_SEG_START)
                    start_reg = longint'(signed'(pwdata));
            end
            if (o_valid && i_ready) begin
                if (expected_motion.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_motion.pop_front();
                    popped = 1;
                    if (o_position !== want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, o_position);
                        fail_count++;
                    end
                    if (o_velocity !== want.vel) begin
                        $error("velocity: expected %0d, got %0d", want.vel, o_velocity);
                        fail_count++;
                    end
                    if (o_acceleration !== want.acc) begin
                        $error("acceleration: expected %0d, got %0d", want.acc, o_acceleration);
                        fail_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $error("saturated: expected %0d, got %0d", want.sat, o_saturated);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_motion.insert(expected_motion.size(), eval_segment(i_sample_time));
                pushed = 1;
            end
            outstanding <= outstanding + pushed - popped;
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

// Top of the trajectory evaluator testbench. This module only makes stimulus
// and gives the verdict; all prediction and comparison lives in the checker
// instantiated beside the block.
module tb;
    import ptpva_pkg::*;

    // Writes to this index lie past the last register and must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Length of the deliberate receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 150;

    // Cycles allowed after the last result for anything stray to appear.
    localparam int SETTLE_CYCLES = 20;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 50;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_sample_time = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_position;
    logic signed [31:0] o_velocity;
    logic signed [31:0] o_acceleration;
    logic               o_saturated;

    int fail_count;
    int outstanding;

    // Set once by the stimulus to ask the receiver for its long hold-off.
    bit hold_off = 1'b0;

    // Number of requests still to go in the sender's current burst.
    int burst_left = 0;

    // Segment to be loaded by the next call of load_segment.
    logic [31:0] seg_coef [NUM_COEF];
    logic [31:0] seg_start;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    poly_trajectory_pos_vel_acc i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_time  (i_sample_time),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_saturated    (o_saturated)
    );

    poly_trajectory_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_time  (i_sample_time),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_saturated    (o_saturated),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // A register write is a setup cycle followed by an access cycle. The bus
    // is deliberately left selected afterwards, so that back-to-back writes
    // never assign psel twice in one time step; bus_idle releases it.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Loads the whole segment, then pokes the unused index with junk, which
    // the block has to ignore.
    task automatic load_segment();
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(REG_COEF_C0 + REG_IDX_W'(k), seg_coef[k]);
        write_reg(REG_SEG_START, seg_start);
        write_reg(REG_UNUSED, $urandom);
        bus_idle();
    endtask

    // Offers one request and returns at the edge where it is taken. Requests
    // come in bursts of random length; between bursts the valid line drops
    // for a random gap, and sometimes there is no gap at all.
    task automatic send_item(input logic [31:0] t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_sample_time <= t;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Waits until every request sent so far has produced its result. The
    // count from the checker is registered, so the first edge is skipped to
    // let a request accepted just now show up in it.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    task automatic send_list(input logic [31:0] pts [$]);
        foreach (pts[n])
            send_item(pts[n]);
        drain();
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Higher powers get smaller coefficients most of the time, otherwise
    // nearly every evaluation would clip and the rounding path would go
    // untested. Full-range words and extremes still turn up now and then.
    function automatic logic [31:0] pick_coef(input int k);
        int span;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            span = 1 << (22 - 3 * k);
            r = $urandom_range(0, 2 * span);
            return 32'(r - span);
        end
        if (r < 8)
            return $urandom;
        return pick_extreme();
    endfunction

    // Most sample times fall within a few seconds of the segment start;
    // the rest are anywhere, at the extremes, or within four LSBs of the start.
    function automatic logic [31:0] pick_sample();
        int r;
        int offset;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            offset = $urandom_range(0, 1 << 20);
            return seg_start + 32'(offset - (1 << 19));
        end
        if (r == 7)
            return $urandom;
        if (r == 8)
            return pick_extreme();
        offset = $urandom_range(0, 8);
        return seg_start + 32'(offset - 4);
    endfunction

    // The receiver runs on a pattern of its own: stretches of steady
    // readiness, random readiness, mostly ready and short stalls. Once asked,
    // it holds off for a long stretch while the sender keeps offering, so
    // that the chain fills and the block has to stall its input.
    initial begin : receiver
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(1, 24);
                repeat (span) begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        2: i_ready <= ($urandom_range(0, 3) != 0);
                        default: i_ready <= 1'b0;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Overall limit, several times the slowest correct run.
    initial begin : watchdog
        #4ms;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] pts [$];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset every register is zero, so all results are
        // zero whatever the sample time.
        pts = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_list(pts);

        // A plausible segment with mixed signs, sampled at the start, between
        // whole seconds, before it, and at both ends of the time range; the
        // last one overflows the time difference.
        seg_coef = '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_8000,
                     32'h0000_1000, 32'hFFFF_FF00, 32'h0000_0010};
        seg_start = 32'h0001_0000;
        load_segment();
        pts = '{32'h0001_0000, 32'h0001_8000, 32'h0003_0000,
                32'hFFFC_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_list(pts);

        // A single least-significant bit in c1 with half-second offsets puts the
        // last position rounding exactly on a tie, on both sides of zero.
        seg_coef = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
                     32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        seg_start = 32'h0000_0000;
        load_segment();
        pts = '{32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000, 32'hFFFE_8000};
        send_list(pts);

        // Largest coefficients and earliest start: the derivative scaling,
        // the Horner steps and the time difference all clip upwards.
        foreach (seg_coef[k])
            seg_coef[k] = 32'h7FFF_FFFF;
        seg_start = 32'h8000_0000;
        load_segment();
        pts = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
        send_list(pts);

        // The mirror image: most negative coefficients, latest start.
        foreach (seg_coef[k])
            seg_coef[k] = 32'h8000_0000;
        seg_start = 32'h7FFF_FFFF;
        load_segment();
        pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
        send_list(pts);

        // Random segments, each sampled many times. One phase carries the
        // long receiver hold-off.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int k = 0; k < NUM_COEF; k++)
                seg_coef[k] = pick_coef(k);
            seg_start = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 1 << 22));
            load_segment();
            if (ph == 3)
                hold_off <= 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_item(pick_sample());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
